// File: rtl/cfsa_pkg.sv
// ----------------------------------------------------------------------------
// cfsa_pkg: shared types and constants for the CAN-to-ASCII line encoder
// Character selection codes, command/status bundles and the nibble-to-hex
// conversion used by the controller and the datapath.
// ----------------------------------------------------------------------------
package cfsa_pkg;

  // Identifier limits and field widths
  localparam int unsigned IdentWidth  = 29;
  localparam int unsigned StdIdWidth  = 11;
  localparam int unsigned LenWidth    = 4;
  localparam int unsigned NumBytes    = 8;
  localparam int unsigned CntWidth    = 4;

  localparam logic [LenWidth-1:0] MaxLength = 4'd8;

  // Index of the first (most significant) identifier digit
  localparam logic [CntWidth-1:0] StdIdTopDigit = 4'd2;
  localparam logic [CntWidth-1:0] ExtIdTopDigit = 4'd7;

  // ASCII codes
  localparam logic [7:0] AsciiCr     = 8'h0D;
  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiStdDat = 8'h74;  // 't'
  localparam logic [7:0] AsciiExtDat = 8'h54;  // 'T'
  localparam logic [7:0] AsciiStdRtr = 8'h72;  // 'r'
  localparam logic [7:0] AsciiExtRtr = 8'h52;  // 'R'

  // Which character the datapath builds for the current transaction
  typedef enum logic [2:0] {
    SEL_TYPE,
    SEL_ID,
    SEL_LEN,
    SEL_DATA,
    SEL_CR,
    SEL_REJ
  } sel_e;

  // Controller to datapath
  typedef struct packed {
    logic                load;  // capture the incoming frame
    logic                emit;  // write a character into the output register
    sel_e                sel;
    logic [CntWidth-1:0] idx;   // digit or nibble index
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                reject;
    logic                ext;
    logic                remote;
    logic [LenWidth-1:0] len;
    logic                out_free;
  } status_t;

  // Convert the low nibble to an uppercase hex digit
  function automatic logic [7:0] nib_to_ascii(logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = AsciiZero + {4'd0, nib};
    end else begin
      res = AsciiUpperA + {4'd0, nib - 4'd10};
    end
    return res;
  endfunction

endpackage

// File: rtl/cfsa_if.sv
// ----------------------------------------------------------------------------
// cfsa_if: valid/ready channels of the CAN-to-ASCII line encoder
// One interface carries a CAN frame, the other one line character.
// ----------------------------------------------------------------------------
interface cfsa_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] ident;
  logic        ext_format;
  logic        remote_req;
  logic [3:0]  length_code;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [7:0]  byte4;
  logic [7:0]  byte5;
  logic [7:0]  byte6;
  logic [7:0]  byte7;

  modport source (
    output valid, ident, ext_format, remote_req, length_code,
           byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
    input  ready
  );
  modport sink (
    input  valid, ident, ext_format, remote_req, length_code,
           byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
    output ready
  );
endinterface

interface cfsa_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  logic       rejected;

  modport source (
    output valid, out_char, last_char, rejected,
    input  ready
  );
  modport sink (
    input  valid, out_char, last_char, rejected,
    output ready
  );
endinterface

// File: rtl/cfsa_dp.sv
// ----------------------------------------------------------------------------
// cfsa_dp: datapath of the CAN-to-ASCII line encoder
// Holds the captured frame, builds the selected character and keeps the
// output register that decouples the line from the downstream sink.
// ----------------------------------------------------------------------------
module cfsa_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [28:0]                ident_i,
  input  logic                       ext_format_i,
  input  logic                       remote_req_i,
  input  logic [3:0]                 length_code_i,
  input  logic [cfsa_pkg::NumBytes-1:0][7:0] bytes_i,
  input  cfsa_pkg::cmd_t             cmd_i,
  output cfsa_pkg::status_t          status_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [7:0]                 out_char_o,
  output logic                       last_char_o,
  output logic                       rejected_o
);

  logic [28:0]                          ident_q;
  logic                                 ext_q;
  logic                                 remote_q;
  logic [3:0]                           len_q;
  logic [cfsa_pkg::NumBytes-1:0][7:0]   data_q;

  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       rej_q, rej_d;

  logic [31:0] ident_pad;
  logic [3:0]  id_nib;
  logic [7:0]  data_byte;
  logic [3:0]  data_nib;
  logic        std_too_wide;

  // Capture the frame on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ident_q  <= ident_i;
      ext_q    <= ext_format_i;
      remote_q <= remote_req_i;
      len_q    <= length_code_i;
      data_q   <= bytes_i;
    end
  end

  // Range checks on the captured frame
  assign std_too_wide = |ident_q[28:cfsa_pkg::StdIdWidth];

  assign status_o.reject   = (len_q > cfsa_pkg::MaxLength) || (!ext_q && std_too_wide);
  assign status_o.ext      = ext_q;
  assign status_o.remote   = remote_q;
  assign status_o.len      = len_q;
  assign status_o.out_free = !valid_q || out_ready_i;

  // Pick the identifier digit and data nibble
  assign ident_pad = {3'd0, ident_q};
  assign id_nib    = ident_pad[cmd_i.idx[2:0]*4 +: 4];
  assign data_byte = data_q[cmd_i.idx[3:1]];
  assign data_nib  = cmd_i.idx[0] ? data_byte[3:0] : data_byte[7:4];

  // Build the next character
  always_comb begin
    char_d = char_q;
    last_d = last_q;
    rej_d  = rej_q;
    if (cmd_i.emit) begin
      last_d = 1'b0;
      rej_d  = 1'b0;
      case (cmd_i.sel)
        cfsa_pkg::SEL_TYPE: begin
          if (remote_q) begin
            char_d = ext_q ? cfsa_pkg::AsciiExtRtr : cfsa_pkg::AsciiStdRtr;
          end else begin
            char_d = ext_q ? cfsa_pkg::AsciiExtDat : cfsa_pkg::AsciiStdDat;
          end
        end
        cfsa_pkg::SEL_ID:   char_d = cfsa_pkg::nib_to_ascii(id_nib);
        cfsa_pkg::SEL_LEN:  char_d = cfsa_pkg::nib_to_ascii(len_q);
        cfsa_pkg::SEL_DATA: char_d = cfsa_pkg::nib_to_ascii(data_nib);
        cfsa_pkg::SEL_CR: begin
          char_d = cfsa_pkg::AsciiCr;
          last_d = 1'b1;
        end
        cfsa_pkg::SEL_REJ: begin
          char_d = 8'd0;
          last_d = 1'b1;
          rej_d  = 1'b1;
        end
        default: begin
          char_d = 8'd0;
        end
      endcase
    end
  end

  // Load on emit, drop once the transaction completes
  always_comb begin
    if (cmd_i.emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    rej_q  <= rej_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;
  assign rejected_o  = rej_q;

endmodule

// File: rtl/cfsa_ctrl.sv
// ----------------------------------------------------------------------------
// cfsa_ctrl: sequencer of the CAN-to-ASCII line encoder
// Walks one frame through type letter, identifier digits, length digit,
// data nibbles and carriage return, one character per free output slot.
// ----------------------------------------------------------------------------
module cfsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 frame_valid_i,
  output logic                 frame_ready_o,
  input  cfsa_pkg::status_t    status_i,
  output cfsa_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TYPE = 3'd1;
  localparam logic [2:0] S_ID   = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;
  localparam logic [2:0] S_CR   = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [cfsa_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic [cfsa_pkg::CntWidth-1:0] last_nib;

  // Index of the final data nibble (length is 1..8 here)
  assign last_nib = {status_i.len[2:0], 1'b0} - 4'd1;

  assign frame_ready_o = (state_q == S_IDLE);

  // Advance the sequence
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    cmd_o.sel = cfsa_pkg::SEL_CR;
    cmd_o.idx = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (frame_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TYPE;
        end
      end
      S_TYPE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.reject) begin
            cmd_o.sel = cfsa_pkg::SEL_REJ;
            state_d   = S_IDLE;
          end else begin
            cmd_o.sel = cfsa_pkg::SEL_TYPE;
            cnt_d     = status_i.ext ? cfsa_pkg::ExtIdTopDigit : cfsa_pkg::StdIdTopDigit;
            state_d   = S_ID;
          end
        end
      end
      S_ID: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = cfsa_pkg::SEL_ID;
          if (cnt_q == '0) begin
            state_d = S_LEN;
          end else begin
            cnt_d = cnt_q - 4'd1;
          end
        end
      end
      S_LEN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = cfsa_pkg::SEL_LEN;
          if (!status_i.remote && (status_i.len != '0)) begin
            cnt_d   = '0;
            state_d = S_DATA;
          end else begin
            state_d = S_CR;
          end
        end
      end
      S_DATA: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = cfsa_pkg::SEL_DATA;
          if (cnt_q == last_nib) begin
            state_d = S_CR;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      S_CR: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = cfsa_pkg::SEL_CR;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // A captured frame always starts with the type slot
  a_load_to_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_TYPE))
    else $error("frame capture not followed by type slot");

  // Data nibbles only for an accepted data frame with bytes
  a_data_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> (!status_i.remote && (status_i.len != '0)
                             && (status_i.len <= cfsa_pkg::MaxLength)
                             && (cnt_q <= last_nib)))
    else $error("data nibble sequence out of range");

  // Identifier digit index stays within the frame format
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ID) |-> (cnt_q <= (status_i.ext ? cfsa_pkg::ExtIdTopDigit
                                                  : cfsa_pkg::StdIdTopDigit)))
    else $error("identifier digit index out of range");

  // A line ends with the carriage return or a rejection, then idles
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && ((cmd_o.sel == cfsa_pkg::SEL_CR) || (cmd_o.sel == cfsa_pkg::SEL_REJ)))
    |=> (state_q == S_IDLE))
    else $error("line end did not return to idle");

  // Never write a character over one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("output register overwritten");

endmodule

// File: rtl/can_frame_to_slcan_ascii.sv
// ----------------------------------------------------------------------------
// can_frame_to_slcan_ascii: CAN frame to serial-line ASCII encoder
// Turns one CAN frame into its text line, one character per transaction.
// ----------------------------------------------------------------------------
// A frame is taken when the encoder is idle and is then sent as a line of
// characters (type letter, 3 or 8 identifier digits, length digit, two
// digits per data byte of a data frame, carriage return), or as a single
// rejection result with character 0 when the length code is above eight or
// a standard identifier exceeds 11 bits. The frame is first captured, then
// each character passes through the output register; a new character is
// written only when that register is free, so sink back-pressure stalls
// the line. The last character of a line carries last_char.
module can_frame_to_slcan_ascii (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfsa_frame_if.sink   frame_i,
  cfsa_char_if.source  char_o
);

  cfsa_pkg::cmd_t                       cmd;
  cfsa_pkg::status_t                    status;
  logic [cfsa_pkg::NumBytes-1:0][7:0]   frame_bytes;

  assign frame_bytes = {frame_i.byte7, frame_i.byte6, frame_i.byte5, frame_i.byte4,
                        frame_i.byte3, frame_i.byte2, frame_i.byte1, frame_i.byte0};

  cfsa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_i.valid),
    .frame_ready_o (frame_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  cfsa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ident_i       (frame_i.ident),
    .ext_format_i  (frame_i.ext_format),
    .remote_req_i  (frame_i.remote_req),
    .length_code_i (frame_i.length_code),
    .bytes_i       (frame_bytes),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (char_o.ready),
    .out_valid_o   (char_o.valid),
    .out_char_o    (char_o.out_char),
    .last_char_o   (char_o.last_char),
    .rejected_o    (char_o.rejected)
  );

endmodule
